// ===== design/tcsbr_pkg.sv =====
`timescale 1ns / 1ps

package tcsbr_pkg;

    localparam int NOW_W        = 32;
    localparam int FRAME_W      = 16;
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 4;
    // call sign threshold is the bit period times four: a left shift by two
    localparam int CALL_SHIFT   = 2;
    localparam int THRESH_W     = FRAME_W + CALL_SHIFT;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 8;

    localparam logic [FRAME_W-1:0] BIT_PERIOD_RESET = 16'd10;
    localparam logic [COUNT_W-1:0] FRAME_BITS       = 4'd8;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             data_level;
        logic             clock_level;
    } sample_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              byte_valid;
    } result_t;

endpackage

// ===== design/two_wire_call_sign_byte_receiver.sv =====
`timescale 1ns / 1ps

// Two-wire call-sign byte receiver.
// Slave channel (s_*): one request per line sample, carrying the clock and
// data line levels and a wrapping millisecond timestamp.
// Master channel (m_*): exactly one request per sample; m_tuser flags a
// completed byte, m_tdata holds it (first bit received is the MSB, zero
// when no byte completes).
// cfg_wen/cfg_wdata write the bit period in ms; a high clock run longer than
// four periods arms a call sign, the falling edge that ends it opens a frame and
// each rising edge shifts in one data bit up to a full byte. Write it only while the block idles.
// A sample accepted into the input register moves into the result register
// once that register has space, and m_tvalid rises when it is loaded.
// Throughput: one sample per cycle while m_tready is high; the state update
// is one subtract and two compares between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers, clears the line
// state and loads a period of 10 ms.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready drops until m_tready returns.
module two_wire_call_sign_byte_receiver (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [tcsbr_pkg::FRAME_W-1:0]   cfg_wdata,   // bit period in ms
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] clock_level, [1] data_level, [33:2] now_ms, [39:34] zero
    input  logic [tcsbr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] byte_value
    output logic [tcsbr_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] byte_valid
    output logic                            m_tuser
);
    import tcsbr_pkg::*;

    logic    in_valid;
    logic    space;
    logic    advance;
    sample_t sample;
    result_t result_next;

    assign advance = in_valid && space;

    tcsbr_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (advance),
        .in_valid (in_valid),
        .sample   (sample)
    );

    tcsbr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .advance     (advance),
        .sample      (sample),
        .result_next (result_next)
    );

    tcsbr_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result_next),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/tcsbr_in_stage.sv =====
`timescale 1ns / 1ps

module tcsbr_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tcsbr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           take,
    output logic                           in_valid,
    output tcsbr_pkg::sample_t             sample
);
    import tcsbr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;
    logic    accept;

    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg.clock_level <= s_tdata[0];
            sample_reg.data_level  <= s_tdata[1];
            sample_reg.now_ms      <= s_tdata[NOW_W+1:2];
        end
    end

    assign in_valid = valid_reg;
    assign sample   = sample_reg;

endmodule

// ===== design/tcsbr_core.sv =====
`timescale 1ns / 1ps

module tcsbr_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [tcsbr_pkg::FRAME_W-1:0] cfg_wdata,
    input  logic                         advance,
    input  tcsbr_pkg::sample_t           sample,
    output tcsbr_pkg::result_t           result_next
);
    import tcsbr_pkg::*;

    logic [FRAME_W-1:0] bit_period_reg;
    logic               last_clock_reg,    last_clock_next;
    logic [NOW_W-1:0]   high_start_ms_reg, high_start_ms_next;
    logic               high_timing_reg,   high_timing_next;
    logic               call_armed_reg,    call_armed_next;
    logic               frame_open_reg,    frame_open_next;
    logic [COUNT_W-1:0] bit_count_reg,     bit_count_next;
    logic [BYTE_W-1:0]  shift_bits_reg,    shift_bits_next;

    logic               falling;
    logic               rising;
    logic [NOW_W-1:0]   elapsed;
    logic [THRESH_W-1:0] threshold;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= BIT_PERIOD_RESET;
        end else if (cfg_wen) begin
            bit_period_reg <= cfg_wdata;
        end
    end

    assign falling   = last_clock_reg && !sample.clock_level;
    assign rising    = !last_clock_reg && sample.clock_level;
    assign elapsed   = sample.now_ms - high_start_ms_reg;
    assign threshold = {bit_period_reg, {CALL_SHIFT{1'b0}}};

    always_comb begin
        high_start_ms_next = high_start_ms_reg;
        high_timing_next   = high_timing_reg;
        call_armed_next    = call_armed_reg;
        frame_open_next    = frame_open_reg;
        bit_count_next     = bit_count_reg;
        shift_bits_next    = shift_bits_reg;
        result_next        = '0;

        // time the high run; arm when it ends long enough
        if (sample.clock_level && last_clock_reg) begin
            if (!high_timing_reg) begin
                high_start_ms_next = sample.now_ms;
                high_timing_next   = 1'b1;
            end
        end else begin
            if (high_timing_reg &&
                (elapsed > {{(NOW_W-THRESH_W){1'b0}}, threshold})) begin
                call_armed_next = 1'b1;
            end
            high_timing_next = 1'b0;
        end

        if (call_armed_next && falling) begin
            frame_open_next = 1'b1;
            call_armed_next = 1'b0;
        end

        if (frame_open_next) begin
            if (rising) begin
                shift_bits_next = {shift_bits_reg[BYTE_W-2:0], sample.data_level};
                bit_count_next  = bit_count_reg + 1'b1;
            end
            if (bit_count_next >= FRAME_BITS) begin
                result_next.byte_valid = 1'b1;
                result_next.byte_value = shift_bits_next;
                bit_count_next         = '0;
                frame_open_next        = 1'b0;
            end
        end

        last_clock_next = sample.clock_level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_clock_reg    <= 1'b0;
            high_start_ms_reg <= '0;
            high_timing_reg   <= 1'b0;
            call_armed_reg    <= 1'b0;
            frame_open_reg    <= 1'b0;
            bit_count_reg     <= '0;
            shift_bits_reg    <= '0;
        end else if (advance) begin
            last_clock_reg    <= last_clock_next;
            high_start_ms_reg <= high_start_ms_next;
            high_timing_reg   <= high_timing_next;
            call_armed_reg    <= call_armed_next;
            frame_open_reg    <= frame_open_next;
            bit_count_reg     <= bit_count_next;
            shift_bits_reg    <= shift_bits_next;
        end
    end

endmodule

// ===== design/tcsbr_out_stage.sv =====
`timescale 1ns / 1ps

module tcsbr_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  tcsbr_pkg::result_t             result,
    output logic                           space,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcsbr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import tcsbr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg.byte_value;
    assign m_tuser  = result_reg.byte_valid;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tcsbr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    // input register plus result register, with some margin
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_ITEMS    = 225;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [FRAME_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // line decoder mirror
    logic [FRAME_W-1:0]   period_ms  = BIT_PERIOD_RESET;
    logic                 prev_clk   = 1'b0;
    logic [NOW_W-1:0]     run_start  = '0;
    logic                 run_timing = 1'b0;
    logic                 call_ready = 1'b0;
    logic                 in_frame   = 1'b0;
    logic [COUNT_W-1:0]   bits_seen  = '0;
    logic [BYTE_W-1:0]    shift_reg  = '0;

    result_t              predicted_results[$];
    logic [NOW_W-1:0]     line_ms        = '0;
    int unsigned          samples_sent   = 0;
    int unsigned          bytes_received = 0;
    int unsigned          mismatches     = 0;
    int unsigned          quiet_cycles   = 0;
    int unsigned          send_idle_pct  = 0;
    int unsigned          recv_stall_pct = 0;

    two_wire_call_sign_byte_receiver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Advance the decoder mirror by one sample and queue the result it yields.
    function automatic void decode_line_sample(input sample_t smp);
        logic             falling;
        logic             rising;
        logic [NOW_W-1:0] elapsed;
        result_t          res;
        falling = prev_clk && !smp.clock_level;
        rising  = !prev_clk && smp.clock_level;
        res     = '0;
        if (smp.clock_level && prev_clk) begin
            if (!run_timing) begin
                run_start  = smp.now_ms;
                run_timing = 1'b1;
            end
        end else begin
            if (run_timing) begin
                elapsed = smp.now_ms - run_start;
                if (elapsed > {{(NOW_W-THRESH_W){1'b0}}, period_ms, 2'b00})
                    call_ready = 1'b1;
            end
            run_timing = 1'b0;
        end
        if (call_ready && falling) begin
            in_frame   = 1'b1;
            call_ready = 1'b0;
        end
        if (in_frame) begin
            if (rising) begin
                shift_reg = {shift_reg[BYTE_W-2:0], smp.data_level};
                bits_seen = bits_seen + 1'b1;
            end
            if (bits_seen >= FRAME_BITS) begin
                res.byte_valid = 1'b1;
                res.byte_value = shift_reg;
                bits_seen      = '0;
                in_frame       = 1'b0;
            end
        end
        prev_clk = smp.clock_level;
        predicted_results.push_back(res);
    endfunction

    // Send one line sample stamped with line_ms; valid stays high on return.
    task automatic push_sample(input logic clk_lvl, input logic dat_lvl);
        sample_t smp;
        smp.clock_level = clk_lvl;
        smp.data_level  = dat_lvl;
        smp.now_ms      = line_ms;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-NOW_W-2){1'b0}}, smp};
        do @(posedge aclk); while (!s_tready);
        decode_line_sample(smp);
        samples_sent++;
    endtask

    task automatic load_period(input logic [FRAME_W-1:0] value);
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        period_ms = value;
    endtask

    // Hold the clock line high for hold_ms between the second high sample
    // and the falling edge that ends the run.
    task automatic send_call_sign(input int unsigned hold_ms, input int unsigned extra_highs);
        logic [NOW_W-1:0] t0;
        push_sample(1'b0, coin());
        line_ms += $urandom_range(0, 3);
        push_sample(1'b1, coin());
        line_ms += $urandom_range(0, 3);
        t0 = line_ms;
        push_sample(1'b1, coin());
        repeat (extra_highs) begin
            line_ms = t0 + $urandom_range(0, hold_ms);
            push_sample(1'b1, coin());
        end
        line_ms = t0 + hold_ms;
        push_sample(1'b0, coin());
    endtask

    // Clock out the top nbits of value, MSB first, one rising edge per bit.
    task automatic send_bits(input logic [BYTE_W-1:0] value, input int nbits);
        int unsigned thresh;
        thresh = 32'(period_ms) << CALL_SHIFT;
        for (int i = BYTE_W - 1; i >= BYTE_W - nbits; i--) begin
            push_sample(1'b0, coin());
            line_ms += $urandom_range(0, 2);
            push_sample(1'b1, value[i]);
            line_ms += $urandom_range(0, 2);
            // linger high now and then, sometimes long enough to re-arm mid-frame
            if ($urandom_range(0, 9) == 0) begin
                push_sample(1'b1, coin());
                line_ms += $urandom_range(0, thresh + 2);
            end
        end
        push_sample(1'b0, coin());
    endtask

    task automatic run_line_traffic(input int unsigned item_goal);
        int unsigned thresh;
        int unsigned goal_end;
        int unsigned pick;
        int unsigned hold;
        thresh   = 32'(period_ms) << CALL_SHIFT;
        goal_end = samples_sent + item_goal;
        while (samples_sent < goal_end) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 15) == 0)
                line_ms = 32'hFFFF_FFFF - $urandom_range(0, thresh + 8);
            if (pick < 70) begin
                case ($urandom_range(0, 3))
                    0: hold = thresh + 1;
                    1: hold = thresh;
                    default: hold = thresh + $urandom_range(1, 500);
                endcase
                send_call_sign(hold, $urandom_range(0, 3));
                send_bits(8'($urandom), BYTE_W);
            end else if (pick < 85) begin
                // marginal call sign followed by a truncated byte
                send_call_sign($urandom_range(0, thresh + 1), $urandom_range(0, 2));
                send_bits(8'($urandom), $urandom_range(1, BYTE_W - 1));
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(0, 7) == 0)
                        line_ms = $urandom;
                    else
                        line_ms += $urandom_range(0, thresh + 2);
                    push_sample(coin(), coin());
                end
            end
        end
    endtask

    task automatic run_period_phase(input logic [FRAME_W-1:0] value,
                                    input int unsigned send_pct, input int unsigned recv_pct);
        load_period(value);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        run_line_traffic(PHASE_ITEMS);
    endtask

    // High run straddles the timestamp wrap; the arming falling edge opens the frame.
    task automatic test_wrapped_call_and_byte();
        line_ms = 32'hFFFF_FFFE;
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b1);
        line_ms = 32'hFFFF_FFFF;
        push_sample(1'b1, 1'b0);
        line_ms = 32'd40;
        push_sample(1'b0, 1'b1);
        send_bits(8'hA5, BYTE_W);
    endtask

    // A run of exactly four periods must not arm.
    task automatic test_call_threshold();
        line_ms = '0;
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);
        line_ms = 32'(BIT_PERIOD_RESET) << CALL_SHIFT;
        push_sample(1'b0, 1'b0);
        line_ms += 1;
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b0);
    endtask

    task automatic test_min_period();
        run_period_phase(16'd1, 0, 0);
    endtask

    task automatic test_zero_period();
        run_period_phase(16'd0, 47, 0);
    endtask

    task automatic test_max_period();
        run_period_phase(16'hFFFF, 0, 47);
    endtask

    task automatic test_random_period();
        run_period_phase(16'($urandom_range(2, 65534)), 17, 17);
    endtask

    task automatic test_reset_period();
        run_period_phase(BIT_PERIOD_RESET, 17, 17);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_wrapped_call_and_byte();
        test_call_threshold();
        test_min_period();
        test_zero_period();
        test_max_period();
        test_random_period();
        test_reset_period();
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d line samples over periods 0, 1, 10, 65535 and one random,",
                 samples_sent);
        $display("with %0d bytes decoded and %0d mismatches.", bytes_received, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_results.size() == 0) begin
                $error("result with none expected: byte_valid %0d byte_value 0x%02h",
                       m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = predicted_results.pop_front();
                if (m_tuser !== want.byte_valid) begin
                    $error("byte_valid: expected %0d, got %0d", want.byte_valid, m_tuser);
                    mismatches++;
                end
                if (m_tdata !== want.byte_value) begin
                    $error("byte_value: expected 0x%02h, got 0x%02h", want.byte_value, m_tdata);
                    mismatches++;
                end
                if (want.byte_valid)
                    bytes_received++;
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
